// ===== rtl/alu16sf_pkg.sv =====
// Shared opcodes, control bundle and pipeline constants for the ALU.
`timescale 1ns / 1ps
package alu16sf_pkg;

  localparam int FUNC_W = 4;
  // Quotient bits resolved in each divider stage.
  localparam int STEPS_PER_STAGE = 4;

  typedef enum logic [FUNC_W-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_AND = 4'd5,
    OP_OR  = 4'd6,
    OP_XOR = 4'd7,
    OP_NOT = 4'd8,
    OP_NEG = 4'd9,
    OP_INC = 4'd10,
    OP_DEC = 4'd11
  } op_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              err;
    logic              v;
    logic              c;
    logic              a_neg;
    logic              b_neg;
    logic              q_neg;
  } ctl_t;

endpackage

// ===== rtl/alu16_with_status_flags.sv =====
// Path: a request passes the front register, then the divider stages, then the back (output) register.
// Throughput: one request per cycle unless in_stall; the restoring divider resolves
//   four quotient bits per stage, so its stage count sets the depth for every opcode.
// One shared advance enable moves all stages; in_stall follows a stalled, full output.
// Reset (rst, synchronous) clears every stage valid bit; data registers keep junk.
`timescale 1ns / 1ps
module alu16_with_status_flags #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [alu16sf_pkg::FUNC_W-1:0] func,
  input  logic [DATA_WIDTH-1:0]          operand_a,
  input  logic [DATA_WIDTH-1:0]          operand_b,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [DATA_WIDTH-1:0]          result,
  output logic                           zero_flag,
  output logic                           sign_flag,
  output logic                           overflow_flag,
  output logic                           carry_flag,
  output logic                           parity_flag,
  output logic                           divide_error
);
  import alu16sf_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int NSTG = (W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  logic adv;

  // per-stage taps: index 0 is the front register, NSTG the last divider stage
  logic           v_s    [NSTG+1];
  ctl_t           ctl_s  [NSTG+1];
  logic [W-1:0]   res_s  [NSTG+1];
  logic [2*W-1:0] prod_s [NSTG+1];
  logic [W-1:0]   ua_s   [NSTG+1];
  logic [W-1:0]   ub_s   [NSTG+1];
  logic [W-1:0]   rem_s  [NSTG+1];
  logic [W-1:0]   quo_s  [NSTG+1];
  logic [W-1:0]   dvs_s  [NSTG+1];

  // advance the whole pipe unless a finished result is held by the consumer
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  alu16sf_front #(.W(W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .vin       (in_valid),
    .func      (func),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .vout      (v_s[0]),
    .ctl       (ctl_s[0]),
    .res       (res_s[0]),
    .prod      (prod_s[0]),
    .ua        (ua_s[0]),
    .ub        (ub_s[0]),
    .rem       (rem_s[0]),
    .quo       (quo_s[0]),
    .dvs       (dvs_s[0])
  );

  for (genvar i = 0; i < NSTG; i++) begin : g_div
    // the last stage takes whatever quotient bits remain
    localparam int NSTEPS = ((i + 1) * STEPS_PER_STAGE > W) ?
                            (W - i * STEPS_PER_STAGE) : STEPS_PER_STAGE;
    alu16sf_div_stage #(.W(W), .NSTEPS(NSTEPS)) u_div (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .vin     (v_s[i]),
      .ctl_in  (ctl_s[i]),
      .res_in  (res_s[i]),
      .prod_in (prod_s[i]),
      .ua_in   (ua_s[i]),
      .ub_in   (ub_s[i]),
      .rem_in  (rem_s[i]),
      .quo_in  (quo_s[i]),
      .dvs_in  (dvs_s[i]),
      .vout    (v_s[i+1]),
      .ctl     (ctl_s[i+1]),
      .res     (res_s[i+1]),
      .prod    (prod_s[i+1]),
      .ua      (ua_s[i+1]),
      .ub      (ub_s[i+1]),
      .rem     (rem_s[i+1]),
      .quo     (quo_s[i+1]),
      .dvs     (dvs_s[i+1])
    );
  end

  alu16sf_back #(.W(W)) u_back (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .vin           (v_s[NSTG]),
    .ctl           (ctl_s[NSTG]),
    .res_in        (res_s[NSTG]),
    .prod          (prod_s[NSTG]),
    .ua            (ua_s[NSTG]),
    .ub            (ub_s[NSTG]),
    .rem           (rem_s[NSTG]),
    .quo           (quo_s[NSTG]),
    .vout          (out_valid),
    .result        (result),
    .zero_flag     (zero_flag),
    .sign_flag     (sign_flag),
    .overflow_flag (overflow_flag),
    .carry_flag    (carry_flag),
    .parity_flag   (parity_flag),
    .divide_error  (divide_error)
  );

  // back-pressure only ever comes from a held result
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // a divide error clears the result and every other flag
  a_err_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_error) |-> ((result == '0) && !zero_flag && !sign_flag &&
                                     !overflow_flag && !carry_flag && !parity_flag))
    else $error("divide error with nonzero result or flags");

  // the pipe comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

// ===== rtl/alu16sf_front.sv =====
// First pipeline stage: opcode decode, simple ops, multiply, divider setup.
`timescale 1ns / 1ps
module alu16sf_front #(
  parameter int W = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           vin,
  input  logic [alu16sf_pkg::FUNC_W-1:0] func,
  input  logic [W-1:0]                   operand_a,
  input  logic [W-1:0]                   operand_b,
  output logic                           vout,
  output alu16sf_pkg::ctl_t              ctl,
  output logic [W-1:0]                   res,
  output logic [2*W-1:0]                 prod,
  output logic [W-1:0]                   ua,
  output logic [W-1:0]                   ub,
  output logic [W-1:0]                   rem,
  output logic [W-1:0]                   quo,
  output logic [W-1:0]                   dvs
);
  import alu16sf_pkg::*;

  localparam logic [W-1:0] WSIGN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE   = {{(W-1){1'b0}}, 1'b1};

  logic [W:0]     sum, diff;
  logic [W-1:0]   res_next, mag_a, mag_b;
  logic           v_next, c_next, err_next;
  logic [2*W-1:0] prod_next;
  ctl_t           ctl_next;

  assign sum       = {1'b0, operand_a} + {1'b0, operand_b};
  assign diff      = {1'b0, operand_a} - {1'b0, operand_b};
  assign prod_next = $signed(operand_a) * $signed(operand_b);
  assign mag_a     = operand_a[W-1] ? (~operand_a + ONE) : operand_a;
  assign mag_b     = operand_b[W-1] ? (~operand_b + ONE) : operand_b;

  always_comb begin
    res_next = '0;
    v_next   = 1'b0;
    c_next   = 1'b0;
    err_next = 1'b0;
    unique case (func) inside
      OP_ADD: begin
        res_next = sum[W-1:0];
        c_next   = sum[W];
        v_next   = (operand_a[W-1] == operand_b[W-1]) && (sum[W-1] != operand_a[W-1]);
      end
      OP_SUB: begin
        res_next = diff[W-1:0];
        c_next   = diff[W];
        v_next   = (operand_a[W-1] != operand_b[W-1]) && (diff[W-1] != operand_a[W-1]);
      end
      OP_DIV, OP_MOD: err_next = (operand_b == '0);
      OP_AND: begin
        res_next = operand_a & operand_b;
        v_next   = res_next[W-1];
      end
      OP_OR: begin
        res_next = operand_a | operand_b;
        v_next   = res_next[W-1];
      end
      OP_XOR: begin
        res_next = operand_a ^ operand_b;
        v_next   = res_next[W-1];
      end
      OP_NOT: begin
        res_next = ~operand_a;
        c_next   = res_next[W-1];
      end
      OP_NEG: begin
        res_next = ~operand_a + ONE;
        v_next   = (operand_a == WSIGN);
        c_next   = (operand_a != '0);
      end
      OP_INC: begin
        res_next = operand_a + ONE;
        v_next   = (operand_a == (WSIGN - ONE));
        c_next   = (operand_a == '1);
      end
      OP_DEC: begin
        res_next = operand_a - ONE;
        v_next   = (operand_a == WSIGN);
        c_next   = (operand_a == '0);
      end
      default: res_next = '0;
    endcase
  end

  always_comb begin
    ctl_next.func  = func;
    ctl_next.err   = err_next;
    ctl_next.v     = v_next;
    ctl_next.c     = c_next;
    ctl_next.a_neg = operand_a[W-1];
    ctl_next.b_neg = operand_b[W-1];
    ctl_next.q_neg = operand_a[W-1] ^ operand_b[W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (adv) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl  <= ctl_next;
      res  <= res_next;
      prod <= prod_next;
      ua   <= operand_a;
      ub   <= operand_b;
      rem  <= '0;
      quo  <= mag_a;
      dvs  <= mag_b;
    end
  end

endmodule

// ===== rtl/alu16sf_div_stage.sv =====
// One divider stage: NSTEPS restoring-division steps, other fields carried along.
`timescale 1ns / 1ps
module alu16sf_div_stage #(
  parameter int W      = 16,
  parameter int NSTEPS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              vin,
  input  alu16sf_pkg::ctl_t ctl_in,
  input  logic [W-1:0]      res_in,
  input  logic [2*W-1:0]    prod_in,
  input  logic [W-1:0]      ua_in,
  input  logic [W-1:0]      ub_in,
  input  logic [W-1:0]      rem_in,
  input  logic [W-1:0]      quo_in,
  input  logic [W-1:0]      dvs_in,
  output logic              vout,
  output alu16sf_pkg::ctl_t ctl,
  output logic [W-1:0]      res,
  output logic [2*W-1:0]    prod,
  output logic [W-1:0]      ua,
  output logic [W-1:0]      ub,
  output logic [W-1:0]      rem,
  output logic [W-1:0]      quo,
  output logic [W-1:0]      dvs
);
  import alu16sf_pkg::*;

  logic [W-1:0] rem_next, quo_next;

  always_comb begin
    logic [W:0] t;
    logic       qb;
    rem_next = rem_in;
    quo_next = quo_in;
    for (int k = 0; k < NSTEPS; k++) begin
      // shift in the next dividend bit, subtract when it fits
      t = {rem_next, quo_next[W-1]};
      qb = (t >= {1'b0, dvs_in});
      if (qb) begin
        t = t - {1'b0, dvs_in};
      end
      rem_next = t[W-1:0];
      quo_next = {quo_next[W-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (adv) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl  <= ctl_in;
      res  <= res_in;
      prod <= prod_in;
      ua   <= ua_in;
      ub   <= ub_in;
      rem  <= rem_next;
      quo  <= quo_next;
      dvs  <= dvs_in;
    end
  end

endmodule

// ===== rtl/alu16sf_back.sv =====
// Last stage: multiply and divide fixup, result select, flags, output register.
`timescale 1ns / 1ps
module alu16sf_back #(
  parameter int W = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              vin,
  input  alu16sf_pkg::ctl_t ctl,
  input  logic [W-1:0]      res_in,
  input  logic [2*W-1:0]    prod,
  input  logic [W-1:0]      ua,
  input  logic [W-1:0]      ub,
  input  logic [W-1:0]      rem,
  input  logic [W-1:0]      quo,
  output logic              vout,
  output logic [W-1:0]      result,
  output logic              zero_flag,
  output logic              sign_flag,
  output logic              overflow_flag,
  output logic              carry_flag,
  output logic              parity_flag,
  output logic              divide_error
);
  import alu16sf_pkg::*;

  localparam logic [W-1:0] WSIGN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE   = {{(W-1){1'b0}}, 1'b1};

  logic [W-1:0] hi_u, q_s, r_s, r_out;
  logic         v_out, c_out;

  // high half of the unsigned product from the signed one
  assign hi_u = prod[2*W-1:W] + (ctl.a_neg ? ub : '0) + (ctl.b_neg ? ua : '0);
  assign q_s  = ctl.q_neg ? (~quo + ONE) : quo;
  assign r_s  = ctl.a_neg ? (~rem + ONE) : rem;

  always_comb begin
    r_out = res_in;
    v_out = ctl.v;
    c_out = ctl.c;
    case (ctl.func) inside
      OP_MUL: begin
        r_out = prod[W-1:0];
        c_out = (hi_u != '0);
        v_out = !((prod[2*W-1:W-1] == '0) || (prod[2*W-1:W-1] == '1));
      end
      OP_DIV: begin
        r_out = q_s;
        v_out = !ctl.q_neg && (quo == WSIGN);
        c_out = 1'b0;
      end
      OP_MOD: begin
        r_out = r_s;
        v_out = 1'b0;
        c_out = 1'b0;
      end
      default: r_out = res_in;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (adv) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ctl.err) begin
        result        <= '0;
        zero_flag     <= 1'b0;
        sign_flag     <= 1'b0;
        overflow_flag <= 1'b0;
        carry_flag    <= 1'b0;
        parity_flag   <= 1'b0;
        divide_error  <= 1'b1;
      end else begin
        result        <= r_out;
        zero_flag     <= (r_out == '0);
        sign_flag     <= r_out[W-1];
        overflow_flag <= v_out;
        carry_flag    <= c_out;
        parity_flag   <= ^r_out;
        divide_error  <= 1'b0;
      end
    end
  end

endmodule
